// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// TCTL_ASSERT checks on every clk edge outside reset.
// TCTL_ASSERT_ALWAYS checks on every clk edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TCTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TCTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tctl_pkg.sv =====
// ----------------------------------------------------------------------------
// Tag controller package
// Shared types and constants of the two-level cache tag controller.
// ----------------------------------------------------------------------------
package tctl_pkg;

  localparam int LAT_W  = 16;
  localparam int CYC_W  = 18;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 48;
  localparam int ADDR_W = 32;
  localparam int PADDR_W = 4;

  // register index codes (paddr[3:2])
  localparam logic [1:0] REG_L1_LAT  = 2'd0;
  localparam logic [1:0] REG_L2_LAT  = 2'd1;
  localparam logic [1:0] REG_MEM_LAT = 2'd2;
  localparam logic [1:0] REG_ALLOC   = 2'd3;

  // operation applied to one set row
  typedef enum logic [1:0] {
    ROW_NONE,
    ROW_TOUCH,
    ROW_PLACE,
    ROW_DROP
  } row_op_t;

  // controller -> datapath
  typedef struct packed {
    logic    clr;
    logic    start;
    logic    count;
    logic    n_re;
    logic    n_we;
    logic    n_rd_vic;
    logic    n_op_vic;
    row_op_t n_op;
    logic    n_dirty;
    logic    f_re;
    logic    f_we;
    logic    f_rd_vic;
    logic    f_op_vic;
    row_op_t f_op;
    logic    f_dirty;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic is_write;
    logic n_hit;
    logic n_free;
    logic n_vic_dirty;
    logic f_hit;
    logic f_free;
  } ctl_sts_t;

endpackage

// ===== design/tctl_if.sv =====
// ----------------------------------------------------------------------------
// Tag controller channels
// Valid/ready request and result channels.
// ----------------------------------------------------------------------------
interface tctl_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] address;

  modport source (output valid, cmd, address, input ready);
  modport sink   (input valid, cmd, address, output ready);
endinterface

interface tctl_rsp_if;
  logic        valid;
  logic        ready;
  logic        first_level_hit;
  logic        second_level_hit;
  logic [17:0] request_cycles;
  logic [31:0] request_count;
  logic [47:0] cycle_total;
  logic [31:0] first_accesses;
  logic [31:0] first_misses;
  logic [31:0] second_accesses;
  logic [31:0] second_misses;

  modport source (output valid, first_level_hit, second_level_hit, request_cycles,
                  request_count, cycle_total, first_accesses, first_misses,
                  second_accesses, second_misses, input ready);
  modport sink   (input valid, first_level_hit, second_level_hit, request_cycles,
                  request_count, cycle_total, first_accesses, first_misses,
                  second_accesses, second_misses, output ready);
endinterface

// ===== design/tctl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module tctl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tctl_level.sv =====
// ----------------------------------------------------------------------------
// Set row logic
// Lookup, victim choice and LRU update on one set row of one cache level.
// ----------------------------------------------------------------------------
module tctl_level #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 21,
  localparam int RW   = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int EW   = TAG_W + 2 + RW
) (
  input  logic [WAYS*EW-1:0] row_in,
  input  logic [TAG_W-1:0]   tag,
  input  tctl_pkg::row_op_t  op,
  input  logic               mark_dirty,
  output logic [WAYS*EW-1:0] row_out,
  output logic [WAYS*EW-1:0] clr_row,
  output logic               hit,
  output logic               free,
  output logic [TAG_W-1:0]   vic_tag,
  output logic               vic_dirty
);

  logic [TAG_W-1:0] tg [WAYS];
  logic             vl [WAYS];
  logic             dt [WAYS];
  logic [RW-1:0]    rk [WAYS];
  logic [TAG_W-1:0] tg_n [WAYS];
  logic             vl_n [WAYS];
  logic             dt_n [WAYS];
  logic [RW-1:0]    rk_n [WAYS];
  logic [RW-1:0]    hit_way, free_way, old_way, tgt_way, old_rank;
  logic             do_touch;

  // unpack and search
  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_way = '0;
    free_way = '0;
    old_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      tg[i] = row_in[i*EW+RW+2 +: TAG_W];
      vl[i] = row_in[i*EW+RW+1];
      dt[i] = row_in[i*EW+RW];
      rk[i] = row_in[i*EW +: RW];
      if (vl[i] && tg[i] == tag) begin
        hit = 1'b1;
        hit_way = RW'(i);
      end
      if (!vl[i]) begin
        free = 1'b1;
        free_way = RW'(i);
      end
      if (rk[i] == '0) begin
        old_way = RW'(i);
      end
    end
    vic_tag = tg[old_way];
    vic_dirty = dt[old_way];
  end

  // apply the row operation
  always_comb begin
    tgt_way = (op == tctl_pkg::ROW_PLACE) ? (free ? free_way : old_way) : hit_way;
    do_touch = (op == tctl_pkg::ROW_PLACE) || (op == tctl_pkg::ROW_TOUCH && hit);
    old_rank = rk[tgt_way];
    for (int i = 0; i < WAYS; i++) begin
      tg_n[i] = tg[i];
      vl_n[i] = vl[i];
      dt_n[i] = dt[i];
      rk_n[i] = rk[i];
      if (op == tctl_pkg::ROW_DROP && vl[i] && tg[i] == tag) begin
        vl_n[i] = 1'b0;
      end
      if (do_touch) begin
        if (RW'(i) == tgt_way) begin
          rk_n[i] = RW'(WAYS - 1);
          if (op == tctl_pkg::ROW_PLACE) begin
            tg_n[i] = tag;
            vl_n[i] = 1'b1;
            dt_n[i] = mark_dirty;
          end else begin
            dt_n[i] = dt[i] | mark_dirty;
          end
        end else if (rk[i] > old_rank) begin
          rk_n[i] = rk[i] - 1'b1;
        end
      end
      row_out[i*EW +: EW] = {tg_n[i], vl_n[i], dt_n[i], rk_n[i]};
      clr_row[i*EW +: EW] = {{TAG_W{1'b0}}, 2'b00, RW'(i)};
    end
  end

endmodule

// ===== design/tctl_datapath.sv =====
// ----------------------------------------------------------------------------
// Tag controller datapath
// Set row memories of both levels, request register, counters and result.
// ----------------------------------------------------------------------------
module tctl_datapath #(
  parameter int OFFSET_BITS  = 5,
  parameter int NEAR_SETS    = 64,
  parameter int NEAR_WAYS    = 4,
  parameter int FAR_SETS     = 256,
  parameter int FAR_WAYS     = 8,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tctl_pkg::ctl_cmd_t              cmd,
  output tctl_pkg::ctl_sts_t              sts,
  input  logic                            req_cmd,
  input  logic [tctl_pkg::ADDR_W-1:0]     req_address,
  input  logic [tctl_pkg::LAT_W-1:0]      l1_latency,
  input  logic [tctl_pkg::LAT_W-1:0]      l2_latency,
  input  logic [tctl_pkg::LAT_W-1:0]      memory_latency,
  output logic                            first_level_hit,
  output logic                            second_level_hit,
  output logic [tctl_pkg::CYC_W-1:0]      request_cycles,
  output logic [tctl_pkg::CNT_W-1:0]      request_count,
  output logic [tctl_pkg::TOT_W-1:0]      cycle_total,
  output logic [tctl_pkg::CNT_W-1:0]      first_accesses,
  output logic [tctl_pkg::CNT_W-1:0]      first_misses,
  output logic [tctl_pkg::CNT_W-1:0]      second_accesses,
  output logic [tctl_pkg::CNT_W-1:0]      second_misses
);

  localparam int AB    = ADDRESS_BITS;
  localparam int NSB   = $clog2(NEAR_SETS + 1) - 1;
  localparam int FSB   = $clog2(FAR_SETS + 1) - 1;
  localparam int NAW   = (NSB > 0) ? NSB : 1;
  localparam int FAW   = (FSB > 0) ? FSB : 1;
  localparam int ND    = 1 << NSB;
  localparam int FD    = 1 << FSB;
  localparam int NTW   = AB - OFFSET_BITS - NSB;
  localparam int FTW   = AB - OFFSET_BITS - FSB;
  localparam int NRW   = (NEAR_WAYS > 1) ? $clog2(NEAR_WAYS) : 1;
  localparam int FRW   = (FAR_WAYS > 1) ? $clog2(FAR_WAYS) : 1;
  localparam int NROW  = NEAR_WAYS * (NTW + 2 + NRW);
  localparam int FROW  = FAR_WAYS * (FTW + 2 + FRW);
  localparam int CLR_N = (ND > FD) ? ND : FD;
  localparam int CAW   = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  // address split helpers
  function automatic logic [NAW-1:0] n_set(input logic [AB-1:0] a);
    logic [AB-1:0] s;
    s = (a >> OFFSET_BITS) & AB'(ND - 1);
    return NAW'(s);
  endfunction

  function automatic logic [FAW-1:0] f_set(input logic [AB-1:0] a);
    logic [AB-1:0] s;
    s = (a >> OFFSET_BITS) & AB'(FD - 1);
    return FAW'(s);
  endfunction

  function automatic logic [NTW-1:0] n_tag(input logic [AB-1:0] a);
    return NTW'(a >> (OFFSET_BITS + NSB));
  endfunction

  function automatic logic [FTW-1:0] f_tag(input logic [AB-1:0] a);
    return FTW'(a >> (OFFSET_BITS + FSB));
  endfunction

  logic [AB-1:0]   addr_q;
  logic            wr_q;
  logic [CAW-1:0]  clr_cnt;
  logic [AB-1:0]   fv_addr, nv_addr, n_sel_addr, f_sel_addr;
  logic [NROW-1:0] n_rdata, n_row_out, n_clr_row, n_wdata;
  logic [FROW-1:0] f_rdata, f_row_out, f_clr_row, f_wdata;
  logic [NAW-1:0]  n_raddr, n_waddr;
  logic [FAW-1:0]  f_raddr, f_waddr;
  logic [NTW-1:0]  n_vic_tag;
  logic [FTW-1:0]  f_vic_tag;
  logic            n_hit, n_free, n_vic_dirty, f_hit, f_free, f_vic_dirty;
  logic [tctl_pkg::CYC_W-1:0] cyc;
  logic [tctl_pkg::TOT_W:0]   tot_sum;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_q <= req_address[AB-1:0];
      wr_q   <= req_cmd;
    end
  end

  // clearing pass index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // victim line addresses, rebuilt from the held rows
  always_comb begin
    fv_addr = (AB'(f_vic_tag) << (OFFSET_BITS + FSB))
            | (AB'(f_set(addr_q) & FAW'(FD - 1)) << OFFSET_BITS);
    nv_addr = (AB'(n_vic_tag) << (OFFSET_BITS + NSB))
            | (AB'(n_set(addr_q) & NAW'(ND - 1)) << OFFSET_BITS);
    n_sel_addr = cmd.n_op_vic ? fv_addr : addr_q;
    f_sel_addr = cmd.f_op_vic ? nv_addr : addr_q;
    n_raddr = cmd.n_rd_vic ? n_set(fv_addr) : n_set(addr_q);
    f_raddr = cmd.f_rd_vic ? f_set(nv_addr) : f_set(addr_q);
    n_waddr = cmd.clr ? NAW'(clr_cnt) : n_set(n_sel_addr);
    f_waddr = cmd.clr ? FAW'(clr_cnt) : f_set(f_sel_addr);
    n_wdata = cmd.clr ? n_clr_row : n_row_out;
    f_wdata = cmd.clr ? f_clr_row : f_row_out;
  end

  tctl_ram #(.WIDTH(NROW), .DEPTH(ND)) u_near_ram (
    .clk   (clk),
    .we    (cmd.n_we | cmd.clr),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (cmd.n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  tctl_ram #(.WIDTH(FROW), .DEPTH(FD)) u_far_ram (
    .clk   (clk),
    .we    (cmd.f_we | cmd.clr),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (cmd.f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  tctl_level #(.WAYS(NEAR_WAYS), .TAG_W(NTW)) u_near_row (
    .row_in     (n_rdata),
    .tag        (n_tag(n_sel_addr)),
    .op         (cmd.n_op),
    .mark_dirty (cmd.n_dirty),
    .row_out    (n_row_out),
    .clr_row    (n_clr_row),
    .hit        (n_hit),
    .free       (n_free),
    .vic_tag    (n_vic_tag),
    .vic_dirty  (n_vic_dirty)
  );

  tctl_level #(.WAYS(FAR_WAYS), .TAG_W(FTW)) u_far_row (
    .row_in     (f_rdata),
    .tag        (f_tag(f_sel_addr)),
    .op         (cmd.f_op),
    .mark_dirty (cmd.f_dirty),
    .row_out    (f_row_out),
    .clr_row    (f_clr_row),
    .hit        (f_hit),
    .free       (f_free),
    .vic_tag    (f_vic_tag),
    .vic_dirty  (f_vic_dirty)
  );

  // status to the controller
  always_comb begin
    sts.clr_done    = (clr_cnt == CAW'(CLR_N - 1));
    sts.is_write    = wr_q;
    sts.n_hit       = n_hit;
    sts.n_free      = n_free;
    sts.n_vic_dirty = n_vic_dirty;
    sts.f_hit       = f_hit;
    sts.f_free      = f_free;
  end

  // latency of this request
  always_comb begin
    cyc = tctl_pkg::CYC_W'(l1_latency);
    if (!n_hit) begin
      cyc = cyc + tctl_pkg::CYC_W'(l2_latency);
      if (!f_hit) begin
        cyc = cyc + tctl_pkg::CYC_W'(memory_latency);
      end
    end
    tot_sum = {1'b0, cycle_total} + (tctl_pkg::TOT_W+1)'(cyc);
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.count) begin
      first_level_hit  <= n_hit;
      second_level_hit <= !n_hit && f_hit;
      request_cycles   <= cyc;
    end
  end

  // saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      request_count   <= '0;
      cycle_total     <= '0;
      first_accesses  <= '0;
      first_misses    <= '0;
      second_accesses <= '0;
      second_misses   <= '0;
    end else if (cmd.count) begin
      if (request_count != '1) request_count <= request_count + 1'b1;
      if (first_accesses != '1) first_accesses <= first_accesses + 1'b1;
      cycle_total <= tot_sum[tctl_pkg::TOT_W] ? '1 : tot_sum[tctl_pkg::TOT_W-1:0];
      if (!n_hit) begin
        if (first_misses != '1) first_misses <= first_misses + 1'b1;
        if (second_accesses != '1) second_accesses <= second_accesses + 1'b1;
        if (!f_hit && second_misses != '1) second_misses <= second_misses + 1'b1;
      end
    end
  end

endmodule

// ===== design/tctl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tag controller sequencer
// Steps one request through lookup, fills, evictions and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tctl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               alloc_cfg,
  input  tctl_pkg::ctl_sts_t sts,
  output tctl_pkg::ctl_cmd_t cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_FV    = 4'd4;
  localparam logic [3:0] S_NF_RD = 4'd5;
  localparam logic [3:0] S_NF    = 4'd6;
  localparam logic [3:0] S_NV    = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0] state, state_next;
  logic       alloc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign alloc     = !sts.is_write || alloc_cfg;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.n_re = 1'b1;
        cmd.f_re = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.count = 1'b1;
        if (sts.n_hit) begin
          cmd.n_we = 1'b1;
          cmd.n_op = tctl_pkg::ROW_TOUCH;
          cmd.n_dirty = sts.is_write;
          state_next = S_RESP;
        end else if (sts.f_hit) begin
          cmd.f_we = 1'b1;
          cmd.f_op = tctl_pkg::ROW_TOUCH;
          cmd.f_dirty = !alloc;
          state_next = alloc ? S_NF_RD : S_RESP;
        end else if (!alloc) begin
          state_next = S_RESP;
        end else if (sts.f_free) begin
          cmd.f_we = 1'b1;
          cmd.f_op = tctl_pkg::ROW_PLACE;
          state_next = S_NF_RD;
        end else begin
          // far set full: fetch the near row holding the far victim
          cmd.n_re = 1'b1;
          cmd.n_rd_vic = 1'b1;
          state_next = S_FV;
        end
      end
      S_FV: begin
        cmd.n_we = 1'b1;
        cmd.n_op_vic = 1'b1;
        cmd.n_op = tctl_pkg::ROW_DROP;
        cmd.f_we = 1'b1;
        cmd.f_op = tctl_pkg::ROW_PLACE;
        state_next = S_NF_RD;
      end
      S_NF_RD: begin
        cmd.n_re = 1'b1;
        state_next = S_NF;
      end
      S_NF: begin
        if (!sts.n_free && sts.n_vic_dirty) begin
          // dirty near victim: fetch its far row
          cmd.f_re = 1'b1;
          cmd.f_rd_vic = 1'b1;
          state_next = S_NV;
        end else begin
          cmd.n_we = 1'b1;
          cmd.n_op = tctl_pkg::ROW_PLACE;
          cmd.n_dirty = sts.is_write;
          state_next = S_RESP;
        end
      end
      S_NV: begin
        cmd.f_we = 1'b1;
        cmd.f_op_vic = 1'b1;
        cmd.f_op = tctl_pkg::ROW_TOUCH;
        cmd.f_dirty = 1'b1;
        cmd.n_we = 1'b1;
        cmd.n_op = tctl_pkg::ROW_PLACE;
        cmd.n_dirty = sts.is_write;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `TCTL_ASSERT(a_one_side, !(in_ready && out_valid), "request taken while result pending")
  `TCTL_ASSERT(a_near_port, !(cmd.n_re && cmd.n_we), "near row read and written together")
  `TCTL_ASSERT(a_resp_hold, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `TCTL_ASSERT(a_accept_read, (in_valid && in_ready) |=> (cmd.n_re && cmd.f_re), "lookup missed")

endmodule

// ===== design/two_level_cache_tag_controller.sv =====
// On an L1 hit the result becomes valid after the read and lookup states; a
// miss that evicts in both levels also passes the fill and eviction states.
// The next request is accepted in the cycle after the result is taken, so a
// new request is not taken until the previous result has been taken.
// After rst a clearing pass resets the set rows up to max(NEAR_SETS,
// FAR_SETS) (power-of-two floor); no request is taken meanwhile, APB works always.
// ----------------------------------------------------------------------------
// Two-level cache tag controller
// Inclusive L1/L2 tag model with true LRU, write-back and hit statistics.
// ----------------------------------------------------------------------------
module two_level_cache_tag_controller #(
  parameter int OFFSET_BITS  = 5,
  parameter int NEAR_SETS    = 64,
  parameter int NEAR_WAYS    = 4,
  parameter int FAR_SETS     = 256,
  parameter int FAR_WAYS     = 8,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  tctl_req_if.sink                        req,
  tctl_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tctl_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [tctl_pkg::LAT_W-1:0] l1_latency, l2_latency, memory_latency;
  logic                       allocate_on_write;
  tctl_pkg::ctl_cmd_t         cmd;
  tctl_pkg::ctl_sts_t         sts;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_latency        <= 16'd1;
      l2_latency        <= 16'd10;
      memory_latency    <= 16'd100;
      allocate_on_write <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        tctl_pkg::REG_L1_LAT:  l1_latency <= pwdata[15:0];
        tctl_pkg::REG_L2_LAT:  l2_latency <= pwdata[15:0];
        tctl_pkg::REG_MEM_LAT: memory_latency <= pwdata[15:0];
        tctl_pkg::REG_ALLOC:   allocate_on_write <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      tctl_pkg::REG_L1_LAT:  prdata = {16'd0, l1_latency};
      tctl_pkg::REG_L2_LAT:  prdata = {16'd0, l2_latency};
      tctl_pkg::REG_MEM_LAT: prdata = {16'd0, memory_latency};
      tctl_pkg::REG_ALLOC:   prdata = {31'd0, allocate_on_write};
      default:               prdata = '0;
    endcase
  end

  tctl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .alloc_cfg (allocate_on_write),
    .sts       (sts),
    .cmd       (cmd)
  );

  tctl_datapath #(
    .OFFSET_BITS  (OFFSET_BITS),
    .NEAR_SETS    (NEAR_SETS),
    .NEAR_WAYS    (NEAR_WAYS),
    .FAR_SETS     (FAR_SETS),
    .FAR_WAYS     (FAR_WAYS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_cmd          (req.cmd),
    .req_address      (req.address),
    .l1_latency       (l1_latency),
    .l2_latency       (l2_latency),
    .memory_latency   (memory_latency),
    .first_level_hit  (rsp.first_level_hit),
    .second_level_hit (rsp.second_level_hit),
    .request_cycles   (rsp.request_cycles),
    .request_count    (rsp.request_count),
    .cycle_total      (rsp.cycle_total),
    .first_accesses   (rsp.first_accesses),
    .first_misses     (rsp.first_misses),
    .second_accesses  (rsp.second_accesses),
    .second_misses    (rsp.second_misses)
  );

endmodule

// ===== tb/two_level_cache_tag_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Two-level cache tag controller testbench
// Sends read and write requests through the request channel and checks every
// result against a tag-level model of both cache levels. Latencies and the
// write-allocate policy are changed over APB between phases. The address mix
// is aimed at a few crowded sets, so that hits, misses, LRU evictions and
// inclusive drops all occur.
// ----------------------------------------------------------------------------
module two_level_cache_tag_controller_tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic        l1_hit;
    logic        l2_hit;
    logic [17:0] cycles;
    logic [31:0] req_cnt;
    logic [47:0] cyc_tot;
    logic [31:0] l1_acc;
    logic [31:0] l1_miss;
    logic [31:0] l2_acc;
    logic [31:0] l2_miss;
  } lookup_rsp_t;

  typedef struct {
    logic        cmd;
    logic [31:0] addr;
    bit          known;
    logic        l1_hit;
    logic        l2_hit;
    logic [17:0] cycles;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tctl_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tctl_req_if req_ch ();
  tctl_rsp_if rsp_ch ();

  two_level_cache_tag_controller i_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // model state; index 0 is L1, index 1 is L2 (arrays sized for L2)
  logic [20:0] tag_mem [2][2048];
  bit          val_mem [2][2048];
  bit          drt_mem [2][2048];
  int          rank_mem[2][2048];
  logic [15:0] lat_l1, lat_l2, lat_mem;
  logic        alloc_wr;
  logic [31:0] cnt_req, cnt_l1_acc, cnt_l1_miss, cnt_l2_acc, cnt_l2_miss;
  logic [47:0] cnt_cyc;

  lookup_rsp_t pending_rsp[$];
  int n_accepted = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_l1_hits = 0;
  int n_l2_hits = 0;
  int n_writes = 0;
  bit quiet = 1'b0;
  bit long_hold_done = 1'b0;
  int idle_cycles = 0;
  logic [18:0] tag_pool[16];
  logic [7:0]  set_pool[4] = '{8'd0, 8'd64, 8'd200, 8'd255};

  function automatic int ways_of(int lv);
    return lv ? 8 : 4;
  endfunction

  function automatic int sbits_of(int lv);
    return lv ? 8 : 6;
  endfunction

  function automatic int set_of(int lv, logic [31:0] a);
    return int'((a >> 5) & ((32'd1 << sbits_of(lv)) - 1));
  endfunction

  function automatic logic [20:0] tag_of(int lv, logic [31:0] a);
    return 21'(a >> (5 + sbits_of(lv)));
  endfunction

  // move a way to most recent, shifting the newer ones down
  function automatic void touch_way(int lv, int s, int w);
    int base;
    int old;
    base = s * ways_of(lv);
    old = rank_mem[lv][base + w];
    rank_mem[lv][base + w] = ways_of(lv) - 1;
    for (int i = 0; i < ways_of(lv); i++)
      if (i != w && rank_mem[lv][base + i] > old) rank_mem[lv][base + i]--;
  endfunction

  function automatic int probe_way(int lv, logic [31:0] a);
    int k;
    for (int i = 0; i < ways_of(lv); i++) begin
      k = set_of(lv, a) * ways_of(lv) + i;
      if (val_mem[lv][k] && tag_mem[lv][k] == tag_of(lv, a)) return i;
    end
    return -1;
  endfunction

  function automatic int free_way(int lv, int s);
    for (int i = 0; i < ways_of(lv); i++)
      if (!val_mem[lv][s * ways_of(lv) + i]) return i;
    return -1;
  endfunction

  function automatic void mark_line_dirty(int lv, logic [31:0] a);
    int k;
    for (int i = 0; i < ways_of(lv); i++) begin
      k = set_of(lv, a) * ways_of(lv) + i;
      if (val_mem[lv][k] && tag_mem[lv][k] == tag_of(lv, a)) begin
        drt_mem[lv][k] = 1'b1;
        touch_way(lv, set_of(lv, a), i);
      end
    end
  endfunction

  function automatic void drop_line(int lv, logic [31:0] a);
    int k;
    for (int i = 0; i < ways_of(lv); i++) begin
      k = set_of(lv, a) * ways_of(lv) + i;
      if (val_mem[lv][k] && tag_mem[lv][k] == tag_of(lv, a)) val_mem[lv][k] = 1'b0;
    end
  endfunction

  // evict the LRU way when the set is full, then place the line
  function automatic void fill_line(int lv, logic [31:0] a, bit dirty);
    int s;
    int w;
    int vw;
    int nw;
    logic [63:0] va;
    s = set_of(lv, a);
    w = free_way(lv, s);
    if (w < 0) begin
      vw = 0;
      for (int i = ways_of(lv) - 1; i >= 0; i--)
        if (rank_mem[lv][s * ways_of(lv) + i] == 0) vw = i;
      va = (64'(tag_mem[lv][s * ways_of(lv) + vw]) << (5 + sbits_of(lv))) |
           (64'(s) << 5);
      nw = probe_way(0, va[31:0]);
      if (nw >= 0 && drt_mem[0][set_of(0, va[31:0]) * 4 + nw])
        mark_line_dirty(1, va[31:0]);
      drop_line(0, va[31:0]);
      if (lv == 1) drop_line(1, va[31:0]);
      w = free_way(lv, s);
      if (w < 0) w = 0;
    end
    tag_mem[lv][s * ways_of(lv) + w] = tag_of(lv, a);
    val_mem[lv][s * ways_of(lv) + w] = 1'b1;
    drt_mem[lv][s * ways_of(lv) + w] = dirty;
    touch_way(lv, s, w);
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] x);
    return (x == '1) ? x : x + 1;
  endfunction

  // one request through both levels; returns the result it must produce
  function automatic lookup_rsp_t predict_lookup(logic cmd, logic [31:0] a);
    lookup_rsp_t r;
    bit allocate;
    int w;
    logic [17:0] cyc;
    logic [48:0] sum;
    allocate = !cmd || alloc_wr;
    r.l1_hit = 1'b0;
    r.l2_hit = 1'b0;
    cyc = 18'(lat_l1);
    cnt_l1_acc = sat_inc(cnt_l1_acc);
    w = probe_way(0, a);
    if (w >= 0) begin
      r.l1_hit = 1'b1;
      if (cmd) drt_mem[0][set_of(0, a) * 4 + w] = 1'b1;
      touch_way(0, set_of(0, a), w);
    end else begin
      cnt_l1_miss = sat_inc(cnt_l1_miss);
      cyc += 18'(lat_l2);
      cnt_l2_acc = sat_inc(cnt_l2_acc);
      w = probe_way(1, a);
      if (w >= 0) begin
        r.l2_hit = 1'b1;
        if (!allocate) drt_mem[1][set_of(1, a) * 8 + w] = 1'b1;
        touch_way(1, set_of(1, a), w);
      end else begin
        cnt_l2_miss = sat_inc(cnt_l2_miss);
        cyc += 18'(lat_mem);
        if (allocate) fill_line(1, a, 1'b0);
      end
      if (allocate) fill_line(0, a, cmd);
    end
    cnt_req = sat_inc(cnt_req);
    sum = 49'(cnt_cyc) + 49'(cyc);
    cnt_cyc = sum[48] ? '1 : sum[47:0];
    r.cycles = cyc;
    r.req_cnt = cnt_req;
    r.cyc_tot = cnt_cyc;
    r.l1_acc = cnt_l1_acc;
    r.l1_miss = cnt_l1_miss;
    r.l2_acc = cnt_l2_acc;
    r.l2_miss = cnt_l2_miss;
    return r;
  endfunction

  // APB write: setup cycle, then access cycle; the caller releases the bus
  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tctl_pkg::PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tctl_pkg::REG_L1_LAT:  lat_l1 = value[15:0];
      tctl_pkg::REG_L2_LAT:  lat_l2 = value[15:0];
      tctl_pkg::REG_MEM_LAT: lat_mem = value[15:0];
      tctl_pkg::REG_ALLOC:   alloc_wr = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] l1, logic [15:0] l2, logic [15:0] lm,
                            logic alloc);
    apb_write(tctl_pkg::REG_L1_LAT, {16'(~l1), l1});
    apb_write(tctl_pkg::REG_L2_LAT, {16'($urandom), l2});
    apb_write(tctl_pkg::REG_MEM_LAT, {16'($urandom), lm});
    apb_write(tctl_pkg::REG_ALLOC, {31'($urandom), alloc});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // let outstanding work finish before touching the registers
  task automatic wait_idle();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offer one request and hold it until taken; caller decides the next gap
  task automatic send_request(logic cmd, logic [31:0] a, bit known = 1'b0,
                              logic h1 = 1'b0, logic h2 = 1'b0,
                              logic [17:0] cyc = '0);
    lookup_rsp_t r;
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.address <= a;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = predict_lookup(cmd, a);
    if (known) begin
      r.l1_hit = h1;
      r.l2_hit = h2;
      r.cycles = cyc;
    end
    pending_rsp.push_back(r);
    n_accepted++;
    n_writes += cmd;
  endtask

  task automatic request_gap();
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_addr();
    if ($urandom_range(0, 99) < 15) return $urandom;
    return {tag_pool[$urandom_range(0, 15)], set_pool[$urandom_range(0, 3)],
            5'($urandom)};
  endfunction

  task automatic random_requests(int count);
    for (int i = 0; i < count; i++) begin
      send_request(1'($urandom), random_addr());
      request_gap();
    end
    req_ch.valid <= 1'b0;
  endtask

  // directed rows under reset settings
  stim_row_t dir_rows[] = '{
    '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 18'd111},
    '{1'b0, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 18'd1},
    '{1'b1, 32'h0000_001F, 1'b1, 1'b1, 1'b0, 18'd1},
    '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 18'd111},
    '{1'b1, 32'hFFFF_FFE0, 1'b1, 1'b1, 1'b0, 18'd1},
    '{1'b1, 32'h0000_2000, 1'b1, 1'b0, 1'b0, 18'd111},
    '{1'b0, 32'h0000_4000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0000_6000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b1, 32'h0000_8000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0000_A000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0000_C000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0000_E000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0001_2000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b1, 32'h0000_0800, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0000_2000, 1'b0, 1'b0, 1'b0, 18'd0},
    '{1'b0, 32'h0000_0800, 1'b0, 1'b0, 1'b0, 18'd0}
  };

  // response side: check, then pick ready for the next cycle
  initial begin
    int stall_left;
    lookup_rsp_t got;
    lookup_rsp_t want;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.first_level_hit, rsp_ch.second_level_hit,
                rsp_ch.request_cycles, rsp_ch.request_count, rsp_ch.cycle_total,
                rsp_ch.first_accesses, rsp_ch.first_misses,
                rsp_ch.second_accesses, rsp_ch.second_misses};
        if (pending_rsp.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result: %p", got);
        end else begin
          want = pending_rsp.pop_front();
          n_checked++;
          n_l1_hits += want.l1_hit;
          n_l2_hits += want.l2_hit;
          if (got.l1_hit != want.l1_hit || got.l2_hit != want.l2_hit ||
              got.cycles != want.cycles || got.req_cnt != want.req_cnt ||
              got.cyc_tot != want.cyc_tot || got.l1_acc != want.l1_acc ||
              got.l1_miss != want.l1_miss || got.l2_acc != want.l2_acc ||
              got.l2_miss != want.l2_miss) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d mismatch\n  exp %p\n  got %p", n_checked, want, got);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && n_accepted >= 300) begin
        // long hold-off so the block backs up into the request channel
        long_hold_done = 1'b1;
        stall_left = 400;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd = 1'b0;
    req_ch.address = '0;
    for (int l = 0; l < 2; l++)
      for (int k = 0; k < 2048; k++) begin
        tag_mem[l][k] = '0;
        val_mem[l][k] = 1'b0;
        drt_mem[l][k] = 1'b0;
        rank_mem[l][k] = k % ways_of(l);
      end
    lat_l1 = 16'd1;
    lat_l2 = 16'd10;
    lat_mem = 16'd100;
    alloc_wr = 1'b1;
    {cnt_req, cnt_l1_acc, cnt_l1_miss, cnt_l2_acc, cnt_l2_miss} = '0;
    cnt_cyc = '0;
    for (int i = 0; i < 16; i++) tag_pool[i] = 19'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].known,
                   dir_rows[i].l1_hit, dir_rows[i].l2_hit, dir_rows[i].cycles);
      request_gap();
    end
    req_ch.valid <= 1'b0;
    random_requests(220);

    // no write-allocate, zero latencies
    wait_idle();
    set_config(16'd0, 16'd0, 16'd0, 1'b0);
    random_requests(200);

    // largest latencies with allocation
    wait_idle();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    random_requests(160);

    // mixed settings, write-through misses
    wait_idle();
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    random_requests(120);

    // last stretch without idling
    wait_idle();
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    quiet = 1'b1;
    random_requests(130);

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests (%0d writes) checked over 5 register settings",
             n_checked, n_writes);
    $display("L1 hits %0d, L2 hits %0d, mismatches %0d", n_l1_hits, n_l2_hits,
             n_mismatch);
    if (n_mismatch == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
